@@ rtl/aliquot_sum_trial_division_defines.svh @@
// assertion macros used by the rtl files (included by aliq_ctrl)
`ifndef ALIQUOT_SUM_TRIAL_DIVISION_DEFINES_SVH
`define ALIQUOT_SUM_TRIAL_DIVISION_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ALIQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ALIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/aliq_pkg.sv @@
`default_nettype none

package aliq_pkg;

	localparam int NUM_WIDTH_DEF = 20;
	localparam int SUM_WIDTH     = 23;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear_sum;
		logic div_start;
		logic accum;
		logic next_div;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic small_num;
		logic div_done;
		logic quo_lt_div;
		logic rem_zero;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/aliq_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module aliq_div #(
	parameter int W = aliq_pkg::NUM_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int CNT_W = $clog2(W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W:0]       rem_sh;
	logic [W:0]       diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, divisor};
	assign ge     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ rtl/aliq_dpath.sv @@
`default_nettype none

// operand, trial divisor and running sum registers around the divider
module aliq_dpath #(
	parameter int NUM_WIDTH = aliq_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire aliq_pkg::cmd_t                 cmd,
	input  wire logic [NUM_WIDTH-1:0]           number_in,
	output aliq_pkg::status_t                   status,
	output logic [aliq_pkg::SUM_WIDTH-1:0]      divisor_sum
);

	localparam int SW    = aliq_pkg::SUM_WIDTH;
	localparam int ACC_W = ((NUM_WIDTH > SW) ? NUM_WIDTH : SW) + 2;
	localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'({SW{1'b1}});

	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic [SW-1:0]        sum_q;
	logic [NUM_WIDTH-1:0] quo;
	logic [NUM_WIDTH-1:0] rem;
	logic                 div_done;
	logic [ACC_W-1:0]     addend;
	logic [ACC_W-1:0]     total;

	aliq_div #(.W(NUM_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	// divisor plus cofactor, cofactor once on a square
	always_comb begin
		addend = ACC_W'(d_q);
		if (quo != d_q)
			addend = addend + ACC_W'(quo);
		total = ACC_W'(sum_q) + addend;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= number_in;
			d_q   <= NUM_WIDTH'(2);
			sum_q <= SW'(1);
		end else begin
			if (cmd.clear_sum)
				sum_q <= '0;
			else if (cmd.accum)
				sum_q <= (total > SUM_MAX) ? SUM_MAX[SW-1:0] : total[SW-1:0];
			if (cmd.next_div)
				d_q <= d_q + 1'b1;
		end
	end

	assign status.small_num  = (n_q[NUM_WIDTH-1:1] == '0);
	assign status.div_done   = div_done;
	assign status.quo_lt_div = (quo < d_q);
	assign status.rem_zero   = (rem == '0);
	assign divisor_sum       = sum_q;

endmodule

`default_nettype wire

@@ rtl/aliq_ctrl.sv @@
`default_nettype none

`include "aliquot_sum_trial_division_defines.svh"

// sequencer for the trial division walk
module aliq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire aliq_pkg::status_t status,
	output aliq_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] st_q;
	logic [2:0] st_d;

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					st_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.small_num) begin
					cmd.clear_sum = 1'b1;
					st_d          = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					st_d          = S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done)
					st_d = S_EVAL;
			end
			S_EVAL: begin
				// divisor past the square root once quotient drops below it
				if (status.quo_lt_div) begin
					st_d = S_FIN;
				end else begin
					cmd.accum     = status.rem_zero;
					cmd.next_div  = 1'b1;
					cmd.div_start = 1'b1;
					st_d          = S_DIV;
				end
			end
			S_FIN: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= S_IDLE;
		else
			st_q <= st_d;
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_FIN);

	`ALIQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`ALIQ_ASSERT_NEXT(a_done_idle, done, !busy, "block not idle after result strobe")
	`ALIQ_ASSERT_NOW(a_done_src, done, ($past(st_q) == S_CHECK) || ($past(st_q) == S_EVAL), "result strobe from unexpected state")

endmodule

`default_nettype wire

@@ rtl/aliquot_sum_trial_division.sv @@
// aliquot sum by trial division: one word in, one result word out
// inputs below 2 finish straight from the check, else the walk runs one divider pass
// per trial divisor; one word at a time, the next taken the cycle after done;
// the receiver cannot stall, done pulses for one cycle
// reset: arst_n asynchronous active low returns the sequencer to idle, no word pending
`default_nettype none

module aliquot_sum_trial_division #(
	parameter int NUM_WIDTH = aliq_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// command side: word taken when start is high and busy is low
	input  wire logic                      start,
	input  wire logic [NUM_WIDTH-1:0]      number_in,
	output logic                           busy,
	// result side: done marks divisor_sum for exactly one cycle
	output logic                           done,
	output logic [aliq_pkg::SUM_WIDTH-1:0] divisor_sum
);

	aliq_pkg::cmd_t    cmd;
	aliq_pkg::status_t status;

	// controller walks divisors d = 2, 3, ... and stops once n/d < d,
	// which is the same test as d*d > n without a multiplier
	aliq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// datapath holds n, d and a saturating sum; a divisor that divides n adds
	// itself and its cofactor, the cofactor only once when n is d squared
	aliq_dpath #(.NUM_WIDTH(NUM_WIDTH)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.number_in  (number_in),
		.status     (status),
		.divisor_sum(divisor_sum)
	);

endmodule

`default_nettype wire
